// ===== hw/rtl/frame_delta_smoother_defines.svh =====
// ---------------------------------------------------------------------------
// frame delta smoother assertion macros
// shared concurrent assertion forms, clocked on clk and held off in reset
// ---------------------------------------------------------------------------
`ifndef FRAME_DELTA_SMOOTHER_DEFINES_SVH
`define FRAME_DELTA_SMOOTHER_DEFINES_SVH

// same-cycle implication
`define FDS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame delta smoother check failed");

// next-cycle implication
`define FDS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame delta smoother check failed");

`endif

// ===== hw/rtl/fds_pkg.sv =====
// ---------------------------------------------------------------------------
// fds_pkg
// fixed field widths, register indexes, reset values and sequencer states
// ---------------------------------------------------------------------------
package fds_pkg;

  // field widths fixed by the interface
  localparam int DELTA_W  = 24;
  localparam int SCALE_W  = 16;
  localparam int SCALED_W = 32;
  localparam int TOTAL_W  = 48;
  localparam int CFG_W    = 24;
  localparam int REG_IDX_W = 2;
  localparam int FRAC_W   = 8;
  localparam int PROD_W   = DELTA_W + SCALE_W;

  // configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_MAX_DELTA  = 2'd0,
    REG_TIME_SCALE = 2'd1,
    REG_PAUSED     = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_idx_t;

  // register reset values
  localparam logic [DELTA_W-1:0] MAX_DELTA_RST  = 24'hFF_FFFF;
  localparam logic [SCALE_W-1:0] TIME_SCALE_RST = 16'd256;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_UPDT = 5'b00010,
    S_DIV  = 5'b00100,
    S_MUL  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

endpackage

// ===== hw/rtl/fds_ram.sv =====
// ---------------------------------------------------------------------------
// fds_ram
// generic simple dual-port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module fds_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 10,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/fds_div.sv =====
// ---------------------------------------------------------------------------
// fds_div
// serial restoring divider, one quotient bit per cycle, truncating
// ---------------------------------------------------------------------------
module fds_div #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // trial subtract of the divisor from the shifted remainder
  assign trial = {rem_r, q_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = (trial >= {1'b0, den_r});

  // iteration control
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[NUM_W-2:0], fits};
      rem_nxt = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== hw/rtl/frame_delta_smoother.sv =====
// ---------------------------------------------------------------------------
// frame_delta_smoother
// moving average of frame intervals with warm-up, scaling and running total
// ---------------------------------------------------------------------------
// Usage:
//   in_* carries one raw frame interval per valid/ready transfer. Each input
//   gives exactly one result on out_*: the truncated average of the last
//   WINDOW clamped intervals (fewer during warm-up), that average times the
//   Q8.8 time_scale shifted right by eight (zero while paused), and the
//   48-bit wrapping total of all clamped intervals.
//   cfg_wr_en/cfg_index/cfg_wdata write max_delta (0), time_scale (1) and
//   paused (2); write only while no item is in flight.
//   One item is in flight at a time; in_ready rises again as the result is
//   loaded into the output register.
//   A stalled receiver keeps the result in the output register; the next
//   item is accepted and processed meanwhile and waits at its last step.
//   Reset (synchronous, active low) clears ring fill, sum, write slot, total,
//   state, out_valid and config registers; no memory clearing pass is needed.
// ---------------------------------------------------------------------------
`include "frame_delta_smoother_defines.svh"

module frame_delta_smoother #(
  parameter int WINDOW      = 10,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [SAMPLE_BITS-1:0]          in_raw_delta,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [fds_pkg::DELTA_W-1:0]     out_smoothed_delta,
  output logic [fds_pkg::SCALED_W-1:0]    out_scaled_delta,
  output logic [fds_pkg::TOTAL_W-1:0]     out_elapsed_total,
  // configuration port
  input  logic                            cfg_wr_en,
  input  logic [fds_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [fds_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // configuration registers
  logic [fds_pkg::DELTA_W-1:0] max_delta_r;
  logic [fds_pkg::SCALE_W-1:0] time_scale_r;
  logic                        paused_r;

  // control and state
  fds_pkg::state_t         state_r, state_nxt;
  logic [SLOT_W-1:0]       slot_r, slot_nxt;
  logic [CNT_W-1:0]        fill_r, fill_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [fds_pkg::TOTAL_W-1:0] total_r;
  logic [SAMPLE_BITS-1:0]  sample_r;
  logic [fds_pkg::PROD_W-1:0] prod_r;
  logic                    out_valid_r;
  logic [fds_pkg::DELTA_W-1:0]  smooth_r;
  logic [fds_pkg::SCALED_W-1:0] scaled_r;
  logic [fds_pkg::TOTAL_W-1:0]  elapsed_r;

  logic                    in_xfer;
  logic                    out_free;
  logic                    ring_full;
  logic [SAMPLE_BITS-1:0]  clamped;
  logic [SAMPLE_BITS-1:0]  old_sample;
  logic                    ram_wr_en;
  logic                    div_start;
  logic                    div_done;
  logic [SUM_W-1:0]        div_quot;
  logic [fds_pkg::DELTA_W-1:0] avg;
  logic [fds_pkg::SCALE_W-1:0] eff_scale;

  assign in_ready = (state_r == fds_pkg::S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // clamp the incoming interval against max_delta
  always_comb begin
    if (32'(in_raw_delta) > 32'(max_delta_r)) begin
      clamped = SAMPLE_BITS'(max_delta_r);
    end else begin
      clamped = in_raw_delta;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_delta_r  <= fds_pkg::MAX_DELTA_RST;
      time_scale_r <= fds_pkg::TIME_SCALE_RST;
      paused_r     <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (fds_pkg::reg_idx_t'(cfg_index))
        fds_pkg::REG_MAX_DELTA:  max_delta_r  <= cfg_wdata[fds_pkg::DELTA_W-1:0];
        fds_pkg::REG_TIME_SCALE: time_scale_r <= cfg_wdata[fds_pkg::SCALE_W-1:0];
        fds_pkg::REG_PAUSED:     paused_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // interval ring; the oldest entry is read on transfer, overwritten next cycle
  fds_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (slot_r),
    .wr_data (sample_r),
    .rd_en   (in_xfer),
    .rd_addr (slot_r),
    .rd_data (old_sample)
  );

  assign ring_full = (fill_r == CNT_W'(WINDOW));
  assign ram_wr_en = (state_r == fds_pkg::S_UPDT);
  assign div_start = (state_r == fds_pkg::S_UPDT);

  // window update: drop the overwritten entry once the ring is full
  always_comb begin
    sum_nxt  = sum_r + SUM_W'(sample_r) - (ring_full ? SUM_W'(old_sample) : SUM_W'(0));
    fill_nxt = ring_full ? fill_r : fill_r + CNT_W'(1);
    slot_nxt = (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + SLOT_W'(1);
  end

  // average of the window
  fds_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (sum_nxt),
    .den   (fill_nxt),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign avg       = fds_pkg::DELTA_W'(div_quot);
  assign eff_scale = paused_r ? '0 : time_scale_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fds_pkg::S_IDLE: if (in_xfer)  state_nxt = fds_pkg::S_UPDT;
      fds_pkg::S_UPDT:               state_nxt = fds_pkg::S_DIV;
      fds_pkg::S_DIV:  if (div_done) state_nxt = fds_pkg::S_MUL;
      fds_pkg::S_MUL:                state_nxt = fds_pkg::S_DONE;
      fds_pkg::S_DONE: if (out_free) state_nxt = fds_pkg::S_IDLE;
      default:                       state_nxt = fds_pkg::S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fds_pkg::S_IDLE;
      slot_r      <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == fds_pkg::S_UPDT) begin
        slot_r  <= slot_nxt;
        fill_r  <= fill_nxt;
        sum_r   <= sum_nxt;
        total_r <= total_r + fds_pkg::TOTAL_W'(sample_r);
      end
      if (state_r == fds_pkg::S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sample_r <= clamped;
    end
    if (state_r == fds_pkg::S_MUL) begin
      prod_r <= avg * eff_scale;
    end
    if (state_r == fds_pkg::S_DONE && out_free) begin
      smooth_r  <= avg;
      scaled_r  <= prod_r[fds_pkg::FRAC_W +: fds_pkg::SCALED_W];
      elapsed_r <= total_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_smoothed_delta = smooth_r;
  assign out_scaled_delta   = scaled_r;
  assign out_elapsed_total  = elapsed_r;

  // checks
  `FDS_ASSERT_NEXT(a_accept_updates, in_xfer, state_r == fds_pkg::S_UPDT)
  `FDS_ASSERT_SAME(a_fill_bound, 1'b1, fill_r <= CNT_W'(WINDOW))
  `FDS_ASSERT_SAME(a_div_in_div, div_done, state_r == fds_pkg::S_DIV)
  `FDS_ASSERT_NEXT(a_done_loads, state_r == fds_pkg::S_DONE && out_free, out_valid_r)

endmodule
